[design/fadc_multi_hit_pulse_counter_defines.svh]
// ----------------------------------------------------------------------------
// fadc multi-hit pulse counter assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FADC_MULTI_HIT_PULSE_COUNTER_DEFINES_SVH
`define FADC_MULTI_HIT_PULSE_COUNTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MHPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhpc: same-cycle check failed");

// next-cycle implication, disabled in reset
`define MHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhpc: next-cycle check failed");

`endif

[design/mhpc_pkg.sv]
// ----------------------------------------------------------------------------
// mhpc_pkg
// Types, constants and register codes of the multi-hit pulse counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mhpc_pkg;

    // field and counter widths
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 12;
    localparam int HIT_W    = 11;
    localparam int SUM_W    = 28;
    localparam int CFG_IDX_W = 3;

    // saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};

    // divider defaults
    localparam int DIV_DIVIDEND_W = SUM_W;
    localparam int DIV_DIVISOR_W  = COUNT_W;

    // configuration reset values
    localparam logic signed [SAMPLE_W-1:0] ACCEPT_LOW_RST         = 16'sd300;
    localparam logic signed [SAMPLE_W-1:0] ACCEPT_HIGH_RST        = 16'sd600;
    localparam logic signed [SAMPLE_W-1:0] HIT_THRESHOLD_RST      = 16'sd500;
    localparam logic signed [SAMPLE_W-1:0] BASELINE_THRESHOLD_RST = 16'sd505;
    localparam logic [COUNT_W-1:0]         MIN_WIDTH_RST          = 12'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEPT_LOW         = 3'd0,
        REG_ACCEPT_HIGH        = 3'd1,
        REG_HIT_THRESHOLD      = 3'd2,
        REG_BASELINE_THRESHOLD = 3'd3,
        REG_MIN_WIDTH          = 3'd4
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    // input request
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } sample_t;

    // result request
    typedef struct packed {
        logic                       pulse_ended;
        logic [COUNT_W-1:0]         pulse_width;
        logic                       summary_valid;
        logic [HIT_W-1:0]           hit_count;
        logic [HIT_W-1:0]           good_hit_count;
        logic signed [SAMPLE_W-1:0] baseline;
        logic signed [SUM_W-1:0]    pulse_charge;
    } result_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[design/fadc_multi_hit_pulse_counter.sv]
// ----------------------------------------------------------------------------
// fadc_multi_hit_pulse_counter
// Counts negative-going pulses in a digitizer waveform and reports a summary.
// ----------------------------------------------------------------------------
// An ordinary sample is taken and its result is registered at the same
// edge; a new sample is accepted every cycle while the result register is
// not held by result_stall. The sample flagged last_sample starts a summary
// sequence: ST_START loads the divider, ST_DIV runs the 28-step bit-serial
// baseline divider and takes the quotient, ST_MUL does the charge multiply
// and ST_FIN saturates and registers the result, so the last sample of a
// waveform stalls the sample channel through that sequence, plus any wait on
// result_stall.
`timescale 1ns / 1ps
`default_nettype none

`include "fadc_multi_hit_pulse_counter_defines.svh"

module fadc_multi_hit_pulse_counter #(
    parameter int DIVIDEND_W = mhpc_pkg::DIV_DIVIDEND_W,
    parameter int DIVISOR_W  = mhpc_pkg::DIV_DIVISOR_W
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_write,
    input  wire logic [mhpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mhpc_pkg::SAMPLE_W-1:0]         cfg_data,
    // sample channel
    input  wire logic                                  sample_valid,
    output      logic                                  sample_stall,
    input  wire mhpc_pkg::sample_t                     sample_data,
    // result channel
    output      logic                                  result_valid,
    input  wire logic                                  result_stall,
    output      mhpc_pkg::result_t                     result_data
);

    localparam int SW = mhpc_pkg::SAMPLE_W;
    localparam int CW = mhpc_pkg::COUNT_W;
    localparam int HW = mhpc_pkg::HIT_W;
    localparam int MW = mhpc_pkg::SUM_W;

    // configuration registers
    logic signed [SW-1:0] acc_low_reg, acc_high_reg, hit_thr_reg, base_thr_reg;
    logic [CW-1:0]        min_width_reg;

    // waveform state
    logic                 in_pulse_reg, in_pulse_next;
    logic [CW-1:0]        width_reg, width_next;
    logic [HW-1:0]        hits_reg, hits_next;
    logic [HW-1:0]        good_reg, good_next;
    logic [CW-1:0]        above_cnt_reg, above_cnt_next;
    logic signed [MW-1:0] above_sum_reg, above_sum_next;
    logic [CW-1:0]        pulse_cnt_reg, pulse_cnt_next;
    logic signed [MW-1:0] pulse_sum_reg, pulse_sum_next;

    // sequencer and handshake
    mhpc_pkg::state_t     state_reg, state_next;
    logic                 result_valid_reg, result_valid_next;
    mhpc_pkg::result_t    result_reg, result_next;
    logic                 out_free, take, fin_fire, load_step;

    // summary datapath
    logic                 pend_ended_reg, pend_ended_next;
    logic [CW-1:0]        pend_width_reg, pend_width_next;
    logic signed [SW-1:0] base_reg, base_next;
    logic signed [MW-1:0] prod_reg, prod_next;
    logic signed [MW:0]   charge_full;
    logic signed [MW-1:0] charge_sat;

    // per-sample step
    logic signed [SW-1:0] smp;
    logic                 in_win, start_pulse, end_pulse, pulse1;
    logic [HW-1:0]        good1;
    logic [CW-1:0]        width1;
    logic signed [MW-1:0] smp_ext;

    // divider
    mhpc_pkg::div_ctrl_t  div_ctrl;
    mhpc_pkg::div_stat_t  div_stat;
    logic [DIVIDEND_W-1:0] div_dividend, div_quotient, quo_signed;
    logic [DIVISOR_W-1:0] div_divisor;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_low_reg   <= mhpc_pkg::ACCEPT_LOW_RST;
            acc_high_reg  <= mhpc_pkg::ACCEPT_HIGH_RST;
            hit_thr_reg   <= mhpc_pkg::HIT_THRESHOLD_RST;
            base_thr_reg  <= mhpc_pkg::BASELINE_THRESHOLD_RST;
            min_width_reg <= mhpc_pkg::MIN_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mhpc_pkg::REG_ACCEPT_LOW:         acc_low_reg   <= cfg_data;
                mhpc_pkg::REG_ACCEPT_HIGH:        acc_high_reg  <= cfg_data;
                mhpc_pkg::REG_HIT_THRESHOLD:      hit_thr_reg   <= cfg_data;
                mhpc_pkg::REG_BASELINE_THRESHOLD: base_thr_reg  <= cfg_data;
                mhpc_pkg::REG_MIN_WIDTH:          min_width_reg <= cfg_data[CW-1:0];
                default:                          ;
            endcase
        end
    end

    // handshake
    assign out_free     = !result_valid_reg || !result_stall;
    assign sample_stall = !((state_reg == mhpc_pkg::ST_IDLE) && out_free);
    assign take         = sample_valid && !sample_stall;

    // step decode
    assign smp         = sample_data.sample;
    assign smp_ext     = {{(MW-SW){smp[SW-1]}}, smp};
    assign in_win      = (smp <= acc_high_reg) && (smp >= acc_low_reg);
    assign start_pulse = in_win && !in_pulse_reg && (smp < hit_thr_reg);
    assign pulse1      = in_pulse_reg || start_pulse;
    assign end_pulse   = in_win && pulse1 && (smp > hit_thr_reg);
    assign width1      = start_pulse ? '0 : width_reg;
    assign good1       = (start_pulse && (good_reg != mhpc_pkg::HIT_MAX))
                         ? good_reg + 1'b1 : good_reg;

    // waveform state update, cleared after the summary
    always_comb
    begin
        in_pulse_next  = in_pulse_reg;
        width_next     = width_reg;
        hits_next      = hits_reg;
        good_next      = good_reg;
        above_cnt_next = above_cnt_reg;
        above_sum_next = above_sum_reg;
        pulse_cnt_next = pulse_cnt_reg;
        pulse_sum_next = pulse_sum_reg;
        if (take && in_win)
        begin
            if ((smp > base_thr_reg) && (above_cnt_reg != mhpc_pkg::COUNT_MAX))
            begin
                above_cnt_next = above_cnt_reg + 1'b1;
                above_sum_next = above_sum_reg + smp_ext;
            end
            if (start_pulse && (hits_reg != mhpc_pkg::HIT_MAX))
            begin
                hits_next = hits_reg + 1'b1;
            end
            good_next     = good1;
            in_pulse_next = pulse1 && !end_pulse;
            if (end_pulse && (width1 < min_width_reg) && (good1 != '0))
            begin
                good_next = good1 - 1'b1;
            end
            if (pulse1 && (pulse_cnt_reg != mhpc_pkg::COUNT_MAX))
            begin
                pulse_cnt_next = pulse_cnt_reg + 1'b1;
                pulse_sum_next = pulse_sum_reg + smp_ext;
            end
            width_next = (width1 != mhpc_pkg::COUNT_MAX) ? width1 + 1'b1 : width1;
        end
        else if (fin_fire)
        begin
            in_pulse_next  = 1'b0;
            width_next     = '0;
            hits_next      = '0;
            good_next      = '0;
            above_cnt_next = '0;
            above_sum_next = '0;
            pulse_cnt_next = '0;
            pulse_sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pulse_reg  <= 1'b0;
            width_reg     <= '0;
            hits_reg      <= '0;
            good_reg      <= '0;
            above_cnt_reg <= '0;
            above_sum_reg <= '0;
            pulse_cnt_reg <= '0;
            pulse_sum_reg <= '0;
        end
        else
        begin
            in_pulse_reg  <= in_pulse_next;
            width_reg     <= width_next;
            hits_reg      <= hits_next;
            good_reg      <= good_next;
            above_cnt_reg <= above_cnt_next;
            above_sum_reg <= above_sum_next;
            pulse_cnt_reg <= pulse_cnt_next;
            pulse_sum_reg <= pulse_sum_next;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mhpc_pkg::ST_IDLE:
            begin
                if (take && sample_data.last_sample)
                begin
                    state_next = mhpc_pkg::ST_START;
                end
            end
            mhpc_pkg::ST_START: state_next = mhpc_pkg::ST_DIV;
            mhpc_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = mhpc_pkg::ST_MUL;
                end
            end
            mhpc_pkg::ST_MUL:   state_next = mhpc_pkg::ST_FIN;
            mhpc_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = mhpc_pkg::ST_IDLE;
                end
            end
            default:            state_next = mhpc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_ctrl.start = 1'b0;
        fin_fire       = 1'b0;
        load_step      = 1'b0;
        case (state_reg)
            mhpc_pkg::ST_IDLE:  load_step      = take && !sample_data.last_sample;
            mhpc_pkg::ST_START: div_ctrl.start = 1'b1;
            mhpc_pkg::ST_FIN:   fin_fire       = out_free;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // baseline divider: magnitude of the above-baseline sum over its count
    assign div_dividend = above_sum_reg[MW-1] ? DIVIDEND_W'(-above_sum_reg)
                                              : DIVIDEND_W'(above_sum_reg);
    assign div_divisor  = DIVISOR_W'(above_cnt_reg);

    mhpc_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // signed baseline, zero when nothing was above threshold
    assign quo_signed = above_sum_reg[MW-1] ? -div_quotient : div_quotient;

    always_comb
    begin
        base_next = base_reg;
        if (div_stat.done)
        begin
            base_next = (above_cnt_reg == '0) ? '0 : SW'(quo_signed);
        end
    end

    // charge product and saturation
    assign prod_next   = (state_reg == mhpc_pkg::ST_MUL)
                         ? MW'(base_reg * $signed({1'b0, pulse_cnt_reg}))
                         : prod_reg;
    assign charge_full = {prod_reg[MW-1], prod_reg} - {pulse_sum_reg[MW-1], pulse_sum_reg};
    assign charge_sat  = (charge_full[MW] != charge_full[MW-1])
                         ? {charge_full[MW], {(MW-1){!charge_full[MW]}}}
                         : charge_full[MW-1:0];

    // pulse end of the last sample, held for the summary result
    assign pend_ended_next = (take && sample_data.last_sample) ? end_pulse : pend_ended_reg;
    assign pend_width_next = (take && sample_data.last_sample)
                             ? (end_pulse ? width1 : '0) : pend_width_reg;

    // result register
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (load_step)
        begin
            result_next                = '0;
            result_next.pulse_ended    = end_pulse;
            result_next.pulse_width    = end_pulse ? width1 : '0;
            result_valid_next          = 1'b1;
        end
        else if (fin_fire)
        begin
            result_next.pulse_ended    = pend_ended_reg;
            result_next.pulse_width    = pend_width_reg;
            result_next.summary_valid  = 1'b1;
            result_next.hit_count      = hits_reg;
            result_next.good_hit_count = good_reg;
            result_next.baseline       = base_reg;
            result_next.pulse_charge   = charge_sat;
            result_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        pend_ended_reg <= pend_ended_next;
        pend_width_reg <= pend_width_next;
        base_reg       <= base_next;
        prod_reg       <= prod_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // checks
    `MHPC_ASSERT_SAME(a_busy_stalls, clk, rst_n,
        state_reg != mhpc_pkg::ST_IDLE, sample_stall)
    `MHPC_ASSERT_SAME(a_div_done_in_div, clk, rst_n,
        div_stat.done, state_reg == mhpc_pkg::ST_DIV)
    `MHPC_ASSERT_NEXT(a_last_starts_summary, clk, rst_n,
        take && sample_data.last_sample, state_reg == mhpc_pkg::ST_START)
    `MHPC_ASSERT_NEXT(a_fin_clears_state, clk, rst_n,
        fin_fire, (hits_reg == '0) && (above_cnt_reg == '0) && !in_pulse_reg)

endmodule

`default_nettype wire

[design/mhpc_div.sv]
// ----------------------------------------------------------------------------
// mhpc_div
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mhpc_div #(
    parameter int DIVIDEND_W = mhpc_pkg::DIV_DIVIDEND_W,
    parameter int DIVISOR_W  = mhpc_pkg::DIV_DIVISOR_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mhpc_pkg::div_ctrl_t   ctrl,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output      mhpc_pkg::div_stat_t   stat,
    output      logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;
    logic                  last_step;

    // shared subtract: shift in next dividend bit, try the divisor
    assign shifted   = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign trial     = {1'b0, shifted} - {2'b00, dvs_reg};
    assign last_step = (cnt_reg == CNT_W'(DIVIDEND_W - 1));

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (ctrl.start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_W+1])
            begin
                rem_next = trial[DIVISOR_W:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-hit pulse counter. Waveforms are built
// from runs of low and high samples plus noise; a scoreboard predicts every
// result from the accepted requests and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam longint CHARGE_HI    = 134217727;
    localparam longint CHARGE_LO    = -134217728;
    localparam int     BUSY_CYCLES  = 40;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     PHASE_ITEMS  = 195;
    localparam int     DIR_COUNT    = 19;

    // per-waveform prediction and result checking
    class pulse_summary_checker;
        int                expected_dummy;
        int                acc_lo, acc_hi, hit_thr, base_thr;
        int unsigned       min_w;
        bit                in_pulse;
        int unsigned       width_cnt, hits, good_hits, above_cnt, pulse_cnt;
        int                above_sum, pulse_sum;
        mhpc_pkg::result_t expected_results[$];
        int                errors;

        function new();
            acc_lo   = mhpc_pkg::ACCEPT_LOW_RST;
            acc_hi   = mhpc_pkg::ACCEPT_HIGH_RST;
            hit_thr  = mhpc_pkg::HIT_THRESHOLD_RST;
            base_thr = mhpc_pkg::BASELINE_THRESHOLD_RST;
            min_w    = mhpc_pkg::MIN_WIDTH_RST;
            errors   = 0;
            expected_dummy = 0;
            clear_waveform();
        endfunction

        function void clear_waveform();
            in_pulse  = 1'b0;
            width_cnt = 0;
            hits      = 0;
            good_hits = 0;
            above_cnt = 0;
            pulse_cnt = 0;
            above_sum = 0;
            pulse_sum = 0;
        endfunction

        function void write_reg(mhpc_pkg::cfg_reg_t r, logic [15:0] v);
            case (r)
                mhpc_pkg::REG_ACCEPT_LOW:         acc_lo = $signed(v);
                mhpc_pkg::REG_ACCEPT_HIGH:        acc_hi = $signed(v);
                mhpc_pkg::REG_HIT_THRESHOLD:      hit_thr = $signed(v);
                mhpc_pkg::REG_BASELINE_THRESHOLD: base_thr = $signed(v);
                mhpc_pkg::REG_MIN_WIDTH:          min_w = v[11:0];
                default: ;
            endcase
        endfunction

        // predict the result of one accepted request
        function void take_sample(mhpc_pkg::sample_t req);
            int                s;
            int                base;
            longint            charge;
            mhpc_pkg::result_t want;
            s    = $signed(req.sample);
            want = '0;
            if (s >= acc_lo && s <= acc_hi)
            begin
                if (s > base_thr && above_cnt < mhpc_pkg::COUNT_MAX)
                begin
                    above_cnt++;
                    above_sum += s;
                end
                // pulse start
                if (!in_pulse && s < hit_thr)
                begin
                    in_pulse = 1'b1;
                    if (hits < mhpc_pkg::HIT_MAX)
                        hits++;
                    if (good_hits < mhpc_pkg::HIT_MAX)
                        good_hits++;
                    width_cnt = 0;
                end
                // pulse end, the ending sample belongs to the pulse
                if (in_pulse && s > hit_thr)
                begin
                    in_pulse = 1'b0;
                    if (pulse_cnt < mhpc_pkg::COUNT_MAX)
                    begin
                        pulse_cnt++;
                        pulse_sum += s;
                    end
                    if (width_cnt < min_w && good_hits > 0)
                        good_hits--;
                    want.pulse_ended = 1'b1;
                    want.pulse_width = width_cnt[11:0];
                end
                if (in_pulse && pulse_cnt < mhpc_pkg::COUNT_MAX)
                begin
                    pulse_cnt++;
                    pulse_sum += s;
                end
                if (width_cnt < mhpc_pkg::COUNT_MAX)
                    width_cnt++;
            end
            // waveform summary, then start over
            if (req.last_sample)
            begin
                base   = (above_cnt > 0) ? above_sum / int'(above_cnt) : 0;
                charge = longint'(base) * longint'(pulse_cnt) - longint'(pulse_sum);
                if (charge > CHARGE_HI)
                    charge = CHARGE_HI;
                if (charge < CHARGE_LO)
                    charge = CHARGE_LO;
                want.summary_valid  = 1'b1;
                want.hit_count      = hits[10:0];
                want.good_hit_count = good_hits[10:0];
                want.baseline       = base[15:0];
                want.pulse_charge   = charge[27:0];
                clear_waveform();
            end
            expected_results.push_back(want);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(mhpc_pkg::result_t got);
            mhpc_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request waiting: %p", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("pulse_ended", want.pulse_ended, got.pulse_ended);
            compare_field("pulse_width", want.pulse_width, got.pulse_width);
            compare_field("summary_valid", want.summary_valid, got.summary_valid);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("good_hit_count", want.good_hit_count, got.good_hit_count);
            compare_field("baseline", $signed(want.baseline), $signed(got.baseline));
            compare_field("pulse_charge", $signed(want.pulse_charge),
                          $signed(got.pulse_charge));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [mhpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mhpc_pkg::SAMPLE_W-1:0]  cfg_data = '0;
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    mhpc_pkg::sample_t              sample_data = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    mhpc_pkg::result_t              result_data;

    pulse_summary_checker summary_sb;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   cycle_count = 0;

    fadc_multi_hit_pulse_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check accepted results, stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            summary_sb.check_result(result_data);
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int rand_between(int lo, int hi);
        if (hi < lo)
            return int'($urandom_range(0, 65535)) - 32768;
        return lo + $urandom_range(0, hi - lo);
    endfunction

    // a level inside the window, below or above the hit threshold
    function automatic int pick_level(bit want_low);
        int lo, hi;
        if (want_low)
        begin
            lo = summary_sb.acc_lo;
            hi = summary_sb.hit_thr - 1;
            if (hi > summary_sb.acc_hi)
                hi = summary_sb.acc_hi;
        end
        else
        begin
            lo = summary_sb.hit_thr + 1;
            if (lo < summary_sb.acc_lo)
                lo = summary_sb.acc_lo;
            hi = summary_sb.acc_hi;
        end
        return rand_between(lo, hi);
    endfunction

    task automatic send_sample(input mhpc_pkg::sample_t req);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= req;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        summary_sb.take_sample(req);
    endtask

    task automatic send_value(input int s, input bit last);
        mhpc_pkg::sample_t req;
        req.sample      = s[15:0];
        req.last_sample = last;
        send_sample(req);
    endtask

    // let the block drain and finish any summary sequence
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (summary_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (BUSY_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input mhpc_pkg::cfg_reg_t r, input int v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v[15:0];
        @(posedge clk);
        summary_sb.write_reg(r, v[15:0]);
    endtask

    task automatic load_registers(input int lo, input int hi, input int thr,
                                  input int bthr, input int minw);
        wait_idle();
        write_one(mhpc_pkg::REG_ACCEPT_LOW, lo);
        write_one(mhpc_pkg::REG_ACCEPT_HIGH, hi);
        write_one(mhpc_pkg::REG_HIT_THRESHOLD, thr);
        write_one(mhpc_pkg::REG_BASELINE_THRESHOLD, bthr);
        write_one(mhpc_pkg::REG_MIN_WIDTH, minw);
        cfg_write <= 1'b0;
    endtask

    // one waveform of alternating low and high runs with some noise
    task automatic send_waveform(input int len);
        int n, run, roll, s;
        bit low;
        low = $urandom_range(0, 1);
        run = 0;
        for (n = 0; n < len; n++)
        begin
            if (run == 0)
            begin
                low = !low;
                run = low ? $urandom_range(1, 8) : $urandom_range(1, 5);
            end
            run--;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                s = $urandom_range(0, 65535);
            else if (roll < 15)
            begin
                case ($urandom_range(0, 6))
                    0: s = summary_sb.acc_lo;
                    1: s = summary_sb.acc_hi;
                    2: s = summary_sb.hit_thr;
                    3: s = summary_sb.hit_thr - 1;
                    4: s = summary_sb.hit_thr + 1;
                    5: s = summary_sb.base_thr;
                    default: s = summary_sb.base_thr + 1;
                endcase
            end
            else
                s = pick_level(low);
            send_value(s, n == len - 1);
        end
    endtask

    initial
    begin
        int dir_vals[DIR_COUNT];
        bit dir_last[DIR_COUNT];
        int i, phase, sent, len, lo_r, hi_r, thr_r;

        dir_vals = '{32767, -32768, 600, 300, 500, 499, 601, 299, 501, 505,
                     506, 499, 520, 400, 450, 700, 550, 499, 32767};
        dir_last = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     0, 0, 0, 0, 1, 1, 1, 0, 1};
        summary_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 23;
        stall_pct = 46;

        // directed: window edges, threshold equality, narrow pulse, pulse open
        // at the end, last sample outside the window, baseline-only waveform
        for (i = 0; i < DIR_COUNT; i++)
            send_value(dir_vals[i], dir_last[i]);

        // random waveforms over several register settings
        for (phase = 0; phase < 7; phase++)
        begin
            if (phase == 3)
            begin
                gap_pct   = 46;
                stall_pct = 23;
            end
            if (phase == 5)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            lo_r  = rand_between(-32768, 30000);
            hi_r  = rand_between(lo_r, 32767);
            thr_r = rand_between(lo_r, hi_r);
            case (phase)
                0: load_registers(mhpc_pkg::ACCEPT_LOW_RST, mhpc_pkg::ACCEPT_HIGH_RST,
                                  mhpc_pkg::HIT_THRESHOLD_RST,
                                  mhpc_pkg::BASELINE_THRESHOLD_RST,
                                  mhpc_pkg::MIN_WIDTH_RST);
                1: load_registers(-32768, 32767, 0, -50, 0);
                2: load_registers(400, 440, 420, 425, 2048);
                3: load_registers(lo_r, hi_r, thr_r, thr_r + rand_between(-40, 40),
                                  $urandom_range(0, 12));
                4: load_registers(lo_r, hi_r, thr_r, thr_r + rand_between(-40, 40),
                                  $urandom_range(1, 4));
                5: load_registers(-32768, 32767, -32768, 32767, 5);
                default: load_registers(-32768, 32767, 32767, -32768, 2);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                  : $urandom_range(1, 30);
                send_waveform(len);
                sent += len;
            end
        end

        wait_idle();
        if (summary_sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[fadc_multi_hit_pulse_counter.f]
+incdir+design
design/mhpc_pkg.sv
design/mhpc_div.sv
design/fadc_multi_hit_pulse_counter.sv
bench/testbench.sv
